### rtl/ifs_pkg.sv
// shared types, widths and stencil weights for the interface forcing stencil
`default_nettype none
package ifs_pkg;

  // field widths
  localparam int PRESSURE_BITS   = 16;
  localparam int SCALE_BITS      = 32;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int FORCE_BITS      = 42;
  localparam int CELLS           = 6;
  localparam int SIDE_CELLS      = 3;

  // partial sums grow by at most 2 * (2 + 27 + 270) < 2^10
  localparam int SUM_BITS  = PRESSURE_BITS + 10;
  localparam int PROD_BITS = SUM_BITS + SCALE_BITS + 1;
  localparam int EXT_BITS  = (PROD_BITS > SCALE_FRAC_BITS + FORCE_BITS) ?
                             PROD_BITS : SCALE_FRAC_BITS + FORCE_BITS;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS   = CELLS * PRESSURE_BITS;
  localparam int IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int OUT_BITS  = CELLS * FORCE_BITS;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SCALE_LEFT  = 2'd0,
    CFG_SCALE_RIGHT = 2'd1,
    CFG_SELF_LEFT   = 2'd2,
    CFG_SELF_RIGHT  = 2'd3
  } cfg_index_t;

  // pressure positions in an item
  localparam int P_L3 = 0;
  localparam int P_L2 = 1;
  localparam int P_L1 = 2;
  localparam int P_R0 = 3;
  localparam int P_R1 = 4;
  localparam int P_R2 = 5;

  typedef logic signed [PRESSURE_BITS-1:0] press_t;
  typedef logic signed [SUM_BITS-1:0]      sum_t;
  typedef logic        [SCALE_BITS-1:0]    scale_t;
  typedef logic signed [FORCE_BITS-1:0]    force_t;

  // stencil weights
  localparam sum_t W_LO  = sum_t'(2);
  localparam sum_t W_MID = sum_t'(27);
  localparam sum_t W_HI  = sum_t'(270);

  // sign-extend a pressure to sum width
  function automatic sum_t widen(input press_t p);
    return sum_t'(p);
  endfunction

endpackage
`default_nettype wire

### rtl/ifs_stencil.sv
// two pipeline stages: near/far partial sums, then per-side self-term select
`default_nettype none
module ifs_stencil (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ifs_pkg::press_t press [ifs_pkg::CELLS],
  input  wire logic           self_left,
  input  wire logic           self_right,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ifs_pkg::sum_t       stencil [ifs_pkg::CELLS]
);

  ifs_pkg::sum_t l3, l2, l1, r0, r1, r2;
  ifs_pkg::sum_t near_c [ifs_pkg::CELLS];
  ifs_pkg::sum_t far_c  [ifs_pkg::CELLS];
  ifs_pkg::sum_t near   [ifs_pkg::CELLS];
  ifs_pkg::sum_t far    [ifs_pkg::CELLS];
  logic          v1;
  logic          rdy1;
  logic          rdy2;

  // stage handshakes: a stage loads when empty or when it drains
  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // widened pressures
  always_comb begin
    l3 = ifs_pkg::widen(press[ifs_pkg::P_L3]);
    l2 = ifs_pkg::widen(press[ifs_pkg::P_L2]);
    l1 = ifs_pkg::widen(press[ifs_pkg::P_L1]);
    r0 = ifs_pkg::widen(press[ifs_pkg::P_R0]);
    r1 = ifs_pkg::widen(press[ifs_pkg::P_R1]);
    r2 = ifs_pkg::widen(press[ifs_pkg::P_R2]);
  end

  // constant-weight near and far sums for each layer cell
  always_comb begin
    near_c[0] = -(ifs_pkg::W_LO * l1);
    far_c[0]  = ifs_pkg::W_LO * r0;
    near_c[1] = ifs_pkg::W_MID * l1 - ifs_pkg::W_LO * l2;
    far_c[1]  = ifs_pkg::W_LO * r1 - ifs_pkg::W_MID * r0;
    near_c[2] = ifs_pkg::W_MID * l2 - ifs_pkg::W_LO * l3 - ifs_pkg::W_HI * l1;
    far_c[2]  = ifs_pkg::W_HI * r0 - ifs_pkg::W_MID * r1 + ifs_pkg::W_LO * r2;
    near_c[3] = ifs_pkg::W_MID * r1 - ifs_pkg::W_HI * r0 - ifs_pkg::W_LO * r2;
    far_c[3]  = ifs_pkg::W_LO * l3 - ifs_pkg::W_MID * l2 + ifs_pkg::W_HI * l1;
    near_c[4] = ifs_pkg::W_MID * r0 - ifs_pkg::W_LO * r1;
    far_c[4]  = ifs_pkg::W_LO * l2 - ifs_pkg::W_MID * l1;
    near_c[5] = -(ifs_pkg::W_LO * r0);
    far_c[5]  = ifs_pkg::W_LO * l1;
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      near <= near_c;
      far  <= far_c;
    end
  end

  // stage 2: far alone or near plus far, per side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= v1;
    end
    if (rdy2 && v1) begin
      for (int i = 0; i < ifs_pkg::CELLS; i++) begin
        if ((i < ifs_pkg::SIDE_CELLS) ? self_left : self_right) begin
          stencil[i] <= near[i] + far[i];
        end else begin
          stencil[i] <= far[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ifs_scale.sv
// final stage: stencil times side scale, floor shift, low force bits kept
`default_nettype none
module ifs_scale (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ifs_pkg::sum_t   stencil [ifs_pkg::CELLS],
  input  wire ifs_pkg::scale_t scale_left,
  input  wire ifs_pkg::scale_t scale_right,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ifs_pkg::force_t      force_out [ifs_pkg::CELLS]
);

  logic signed [ifs_pkg::PROD_BITS-1:0] prod [ifs_pkg::CELLS];
  logic signed [ifs_pkg::EXT_BITS-1:0]  prod_ext [ifs_pkg::CELLS];

  assign in_ready = !out_valid || out_ready;

  // one signed multiplier per cell, scale taken as unsigned
  always_comb begin
    for (int i = 0; i < ifs_pkg::CELLS; i++) begin
      if (i < ifs_pkg::SIDE_CELLS) begin
        prod[i] = stencil[i] * $signed({1'b0, scale_left});
      end else begin
        prod[i] = stencil[i] * $signed({1'b0, scale_right});
      end
      prod_ext[i] = ifs_pkg::EXT_BITS'(prod[i]);
    end
  end

  // output register; arithmetic shift is the floor
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      for (int i = 0; i < ifs_pkg::CELLS; i++) begin
        force_out[i] <= prod_ext[i][ifs_pkg::SCALE_FRAC_BITS +: ifs_pkg::FORCE_BITS];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/interface_forcing_stencil_top.sv
// top level: stream ports, configuration registers and the three-stage pipeline
//
// Interface forcing stencil for one boundary cell of a partition interface.
// Slave stream s_* carries six signed pressures, three left and three right
// of the interface; master stream m_* carries the six forcing terms.
// An item moves on a rising edge where tvalid and tready are both high.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
// index 0 scale_left, 1 scale_right (unsigned Q16.16), 2 self_left,
// 3 self_right (bit 0). Write it only while no item is in flight.
// Pipeline: stage 1 forms the near and far sums, stage 2 applies the
// self-term flags, stage 3 multiplies by the side scale (one 26x33
// multiplier per cell) and holds the result in the output register.
// m_tvalid rises once the item has passed stage 1, stage 2 and the output register;
// throughput is one item per cycle while m_tready does not stall.
// A stall at m_tready backs up stage by stage; empty stages still fill,
// so s_tready stays high until all three stages hold items.
// Reset clears all stage valid bits and loads scales of 1.0, flags 0.
`default_nettype none
module interface_forcing_stencil_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // left_far3, left_mid2, left_edge1, right_edge0, right_mid1, right_far2
  input  wire logic [ifs_pkg::IN_BYTES*8-1:0]    s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // force_left3, force_left2, force_left1, force_right0, force_right1,
  // force_right2, then zero padding
  output logic [ifs_pkg::OUT_BYTES*8-1:0]        m_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [ifs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ifs_pkg::SCALE_BITS-1:0]    cfg_data
);

  ifs_pkg::scale_t scale_left;
  ifs_pkg::scale_t scale_right;
  logic            self_left;
  logic            self_right;
  ifs_pkg::press_t press   [ifs_pkg::CELLS];
  ifs_pkg::sum_t   stencil [ifs_pkg::CELLS];
  ifs_pkg::force_t force_v [ifs_pkg::CELLS];
  logic            st_valid;
  logic            st_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_left  <= ifs_pkg::scale_t'(65536);
      scale_right <= ifs_pkg::scale_t'(65536);
      self_left   <= 1'b0;
      self_right  <= 1'b0;
    end else if (cfg_we) begin
      unique case (ifs_pkg::cfg_index_t'(cfg_index))
        ifs_pkg::CFG_SCALE_LEFT:  scale_left  <= cfg_data;
        ifs_pkg::CFG_SCALE_RIGHT: scale_right <= cfg_data;
        ifs_pkg::CFG_SELF_LEFT:   self_left   <= cfg_data[0];
        ifs_pkg::CFG_SELF_RIGHT:  self_right  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // unpack pressures
  always_comb begin
    for (int i = 0; i < ifs_pkg::CELLS; i++) begin
      press[i] = s_tdata[i*ifs_pkg::PRESSURE_BITS +: ifs_pkg::PRESSURE_BITS];
    end
  end

  ifs_stencil u_stencil (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .press      (press),
    .self_left  (self_left),
    .self_right (self_right),
    .out_valid  (st_valid),
    .out_ready  (st_ready),
    .stencil    (stencil)
  );

  ifs_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (st_valid),
    .in_ready    (st_ready),
    .stencil     (stencil),
    .scale_left  (scale_left),
    .scale_right (scale_right),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .force_out   (force_v)
  );

  // pack forces, pad to whole bytes
  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < ifs_pkg::CELLS; i++) begin
      m_tdata[i*ifs_pkg::FORCE_BITS +: ifs_pkg::FORCE_BITS] = force_v[i];
    end
  end

endmodule
`default_nettype wire

### tb/tb_interface_forcing_stencil_top.sv
// testbench for the interface forcing stencil: directed and random items checked by a scoreboard
`timescale 1ns / 1ps
module tb_interface_forcing_stencil_top;
  import ifs_pkg::*;

  localparam int IN_W  = IN_BYTES * 8;
  localparam int OUT_W = OUT_BYTES * 8;

  // stencil weights used by the prediction
  localparam longint WT_LO  = 2;
  localparam longint WT_MID = 27;
  localparam longint WT_HI  = 270;

  // expected forcing terms per accepted item, with the register shadow
  class stencil_scoreboard;
    scale_t scale_l;
    scale_t scale_r;
    bit self_l;
    bit self_r;
    logic [OUT_BITS-1:0] expected_forces[$];
    string field_names[CELLS];
    int mismatches;
    int items_seen;
    int results_seen;

    function new();
      scale_l = scale_t'(65536);
      scale_r = scale_t'(65536);
      self_l = 1'b0;
      self_r = 1'b0;
      mismatches = 0;
      items_seen = 0;
      results_seen = 0;
      field_names[0] = "force_left3";
      field_names[1] = "force_left2";
      field_names[2] = "force_left1";
      field_names[3] = "force_right0";
      field_names[4] = "force_right1";
      field_names[5] = "force_right2";
    endfunction

    function void set_reg(cfg_index_t idx, logic [SCALE_BITS-1:0] v);
      case (idx)
        CFG_SCALE_LEFT: scale_l = v;
        CFG_SCALE_RIGHT: scale_r = v;
        CFG_SELF_LEFT: self_l = v[0];
        CFG_SELF_RIGHT: self_r = v[0];
        default: ;
      endcase
    endfunction

    // floor(sum * scale / 2^frac), low force bits kept
    function force_t scaled(longint s, scale_t k);
      longint prod;
      prod = s * longint'(k);
      return force_t'(prod >>> SCALE_FRAC_BITS);
    endfunction

    function logic [OUT_BITS-1:0] forces_for(logic [IN_W-1:0] d);
      longint l3, l2, l1, r0, r1, r2, s;
      longint near_s[CELLS];
      longint far_s[CELLS];
      logic [OUT_BITS-1:0] f;
      bit on_left;
      l3 = longint'(press_t'(d[P_L3*PRESSURE_BITS +: PRESSURE_BITS]));
      l2 = longint'(press_t'(d[P_L2*PRESSURE_BITS +: PRESSURE_BITS]));
      l1 = longint'(press_t'(d[P_L1*PRESSURE_BITS +: PRESSURE_BITS]));
      r0 = longint'(press_t'(d[P_R0*PRESSURE_BITS +: PRESSURE_BITS]));
      r1 = longint'(press_t'(d[P_R1*PRESSURE_BITS +: PRESSURE_BITS]));
      r2 = longint'(press_t'(d[P_R2*PRESSURE_BITS +: PRESSURE_BITS]));
      near_s[0] = -WT_LO * l1;
      far_s[0]  = WT_LO * r0;
      near_s[1] = WT_MID * l1 - WT_LO * l2;
      far_s[1]  = WT_LO * r1 - WT_MID * r0;
      near_s[2] = -WT_LO * l3 + WT_MID * l2 - WT_HI * l1;
      far_s[2]  = WT_HI * r0 - WT_MID * r1 + WT_LO * r2;
      near_s[3] = -WT_HI * r0 + WT_MID * r1 - WT_LO * r2;
      far_s[3]  = WT_LO * l3 - WT_MID * l2 + WT_HI * l1;
      near_s[4] = WT_MID * r0 - WT_LO * r1;
      far_s[4]  = WT_LO * l2 - WT_MID * l1;
      near_s[5] = -WT_LO * r0;
      far_s[5]  = WT_LO * l1;
      f = '0;
      for (int i = 0; i < CELLS; i++) begin
        on_left = (i < SIDE_CELLS);
        s = far_s[i];
        if (on_left ? self_l : self_r) s = s + near_s[i];
        f[i*FORCE_BITS +: FORCE_BITS] = scaled(s, on_left ? scale_l : scale_r);
      end
      return f;
    endfunction

    function void note_item(logic [IN_W-1:0] d);
      expected_forces.push_back(forces_for(d));
      items_seen++;
    endfunction

    function void check_result(logic [OUT_W-1:0] act);
      logic [OUT_BITS-1:0] exp_f;
      force_t e, a;
      results_seen++;
      if (expected_forces.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatches++;
        return;
      end
      exp_f = expected_forces.pop_front();
      for (int i = 0; i < CELLS; i++) begin
        e = exp_f[i*FORCE_BITS +: FORCE_BITS];
        a = act[i*FORCE_BITS +: FORCE_BITS];
        if (e !== a) begin
          $error("%s expected %0d actual %0d", field_names[i], e, a);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_forces.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [SCALE_BITS-1:0] cfg_data = '0;

  int tx_idle_pct = 12;
  int rx_idle_pct = 61;
  int settings_used = 0;
  stencil_scoreboard sb;

  interface_forcing_stencil_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #1000000;
    $display("FAIL interface_forcing_stencil_top");
    $finish;
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata);
    end
  end

  // send one item, with random idle cycles ahead of it
  task automatic send_item(input logic [IN_W-1:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_item(d);
  endtask

  // hold off the sender until every item has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [SCALE_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // flag writes carry junk above bit 0, which must be dropped
  task automatic apply_settings(input scale_t sl, input scale_t sr, input bit fl,
                                input bit fr);
    logic [SCALE_BITS-1:0] junk;
    junk = $urandom;
    write_reg(CFG_SCALE_LEFT, sl);
    write_reg(CFG_SCALE_RIGHT, sr);
    write_reg(CFG_SELF_LEFT, {junk[SCALE_BITS-1:1], fl});
    junk = $urandom;
    write_reg(CFG_SELF_RIGHT, {junk[SCALE_BITS-1:1], fr});
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [IN_W-1:0] pack_item(press_t l3, press_t l2, press_t l1,
                                                press_t r0, press_t r1, press_t r2);
    logic [IN_W-1:0] d;
    d = '0;
    d[P_L3*PRESSURE_BITS +: PRESSURE_BITS] = l3;
    d[P_L2*PRESSURE_BITS +: PRESSURE_BITS] = l2;
    d[P_L1*PRESSURE_BITS +: PRESSURE_BITS] = l1;
    d[P_R0*PRESSURE_BITS +: PRESSURE_BITS] = r0;
    d[P_R1*PRESSURE_BITS +: PRESSURE_BITS] = r1;
    d[P_R2*PRESSURE_BITS +: PRESSURE_BITS] = r2;
    return d;
  endfunction

  // pressures biased toward the extremes
  function automatic press_t rand_press();
    case ($urandom_range(7))
      0: return press_t'(16'h8000);
      1: return press_t'(16'h7FFF);
      2: return press_t'(0);
      3: return press_t'(-1);
      default: return press_t'($urandom);
    endcase
  endfunction

  function automatic scale_t rand_scale();
    case ($urandom_range(3))
      0: return scale_t'($urandom_range(131072));
      1: return scale_t'(32'hFFFF_FFFF - $urandom_range(255));
      default: return scale_t'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [IN_W-1:0] d;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single full-scale pressures at the reset settings
    for (int k = 0; k < 2 * CELLS; k++) begin
      d = '0;
      d[(k % CELLS)*PRESSURE_BITS +: PRESSURE_BITS] = (k < CELLS) ? 16'h7FFF : 16'h8000;
      send_item(d);
    end
    wait_drained();
    repeat (4) @(posedge clk);

    // full-scale scales with self terms on both sides, largest stencil sums
    apply_settings(scale_t'(32'hFFFF_FFFF), scale_t'(32'hFFFF_FFFF), 1'b1, 1'b1);
    send_item(pack_item(-32768, -32768, -32768, -32768, -32768, -32768));
    send_item(pack_item(32767, 32767, 32767, 32767, 32767, 32767));
    send_item('0);
    send_item(pack_item(-32768, 32767, -32768, 32767, -32768, 32767));
    send_item(pack_item(32767, -32768, 32767, -32768, 32767, -32768));
    wait_drained();
    repeat (4) @(posedge clk);

    // random phases, each under its own register setting
    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 61 : 0;
      rx_idle_pct = (seg < 2) ? 61 : (seg < 4) ? 12 : 0;
      case (seg)
        0: apply_settings(scale_t'(0), scale_t'(32'hFFFF_FFFF), 1'b0, 1'b1);
        1: apply_settings(scale_t'(32'hFFFF_FFFF), scale_t'(0), 1'b1, 1'b0);
        2: apply_settings(scale_t'(1), scale_t'(32'h0000_8000), 1'b1, 1'b1);
        3: apply_settings(rand_scale(), rand_scale(), 1'b0, 1'b0);
        default: apply_settings(rand_scale(), rand_scale(), $urandom_range(1),
                                $urandom_range(1));
      endcase
      for (int n = 0; n < 240; n++) begin
        if (n == 120 || $urandom_range(199) == 0) wait_drained();
        send_item(pack_item(rand_press(), rand_press(), rand_press(),
                            rand_press(), rand_press(), rand_press()));
      end
      wait_drained();
      repeat (4) @(posedge clk);
    end

    // tail
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.mismatches++;
    end
    $display("sent %0d pressure items, checked %0d force results", sb.items_seen,
             sb.results_seen);
    $display("covered %0d register settings incl. zero and full-scale scales", settings_used);
    if (sb.mismatches == 0) begin
      $display("PASS interface_forcing_stencil_top");
    end else begin
      $display("FAIL interface_forcing_stencil_top");
    end
    $finish;
  end

endmodule
